// File: src/sfla_pkg.sv
// Package for the sorted free-list allocator: item types, codes and constants.
// Used by every module in src; it depends on nothing.
package sfla_pkg;

   localparam int ARENA_WORDS = 1024;
   localparam int DEFAULT_MAX_SEGMENTS = 64;
   localparam int ADDR_W = 10;
   localparam int LEN_W = 11;
   localparam int EPOCH_W = 8;

   localparam logic [1:0] FIT_FIRST = 2'd0;
   localparam logic [1:0] FIT_BEST = 2'd1;
   localparam logic [1:0] FIT_WORST = 2'd2;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_NO_FIT = 2'd1;
   localparam logic [1:0] STATUS_TABLE_FULL = 2'd2;

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE = 1'b1;

   localparam logic CSR_FIT_MODE = 1'b0;
   localparam logic CSR_ARENA_SIZE = 1'b1;

   typedef struct packed {
      logic              req_type;
      logic [ADDR_W-1:0] alloc_words;
      logic [ADDR_W-1:0] block_address;
   } req_item_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [ADDR_W-1:0] payload_address;
      logic [ADDR_W-1:0] granted_size;
   } rsp_item_type;

   typedef struct packed {
      logic [ADDR_W-1:0] start;
      logic [LEN_W-1:0]  length;
   } seg_type;

   typedef struct packed {
      logic [EPOCH_W-1:0] epoch;
      logic [LEN_W-1:0]   length;
   } blk_entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_SCAN,
      ST_DECIDE,
      ST_UPDATE,
      ST_RESP
   } state_type;

   typedef enum logic [1:0] {
      CMD_HOLD,
      CMD_ROTATE,
      CMD_INIT,
      CMD_UPDATE
   } cell_cmd_type;

   typedef enum logic [2:0] {
      UPD_NONE,
      UPD_MODIFY,
      UPD_DELETE,
      UPD_MODDEL,
      UPD_INSERT
   } upd_kind_type;

   typedef struct packed {
      cell_cmd_type cmd;
      upd_kind_type kind;
      seg_type      seg;
   } cell_ctl_type;

endpackage

// File: src/sfla_cell.sv
// One free-table cell: holds a single segment and trades it with its neighbors.
// Depends on sfla_pkg.
module sfla_cell #(
   parameter int MAX_FREE_SEGMENTS = sfla_pkg::DEFAULT_MAX_SEGMENTS,
   parameter int INDEX = 0,
   parameter int IDX_W = $clog2(MAX_FREE_SEGMENTS)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  sfla_pkg::cell_ctl_type ctl,
   input  logic [IDX_W-1:0]      idx,
   input  sfla_pkg::seg_type     left_seg,
   input  sfla_pkg::seg_type     right_seg,
   output sfla_pkg::seg_type     seg
);
   import sfla_pkg::*;

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);
   localparam logic [IDX_W-1:0] NEXT_IDX = IDX_W'(INDEX + 1);

   seg_type seg_ff;
   seg_type seg_in;

   always_comb begin
      seg_in = seg_ff;
      unique case (ctl.cmd)
         CMD_HOLD: seg_in = seg_ff;
         CMD_ROTATE: seg_in = right_seg;
         CMD_INIT: begin
            if (INDEX == 0) begin
               seg_in = ctl.seg;
            end
         end
         CMD_UPDATE: begin
            case (ctl.kind)
               UPD_MODIFY: begin
                  if (MY_IDX == idx) begin
                     seg_in = ctl.seg;
                  end
               end
               UPD_DELETE: begin
                  if (MY_IDX >= idx) begin
                     seg_in = right_seg;
                  end
               end
               UPD_MODDEL: begin
                  if (NEXT_IDX == idx) begin
                     seg_in = ctl.seg;
                  end else if (MY_IDX >= idx) begin
                     seg_in = right_seg;
                  end
               end
               UPD_INSERT: begin
                  if (MY_IDX == idx) begin
                     seg_in = ctl.seg;
                  end else if (MY_IDX > idx) begin
                     seg_in = left_seg;
                  end
               end
               default: seg_in = seg_ff;
            endcase
         end
         default: seg_in = seg_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_ff <= '{start: '0, length: LEN_W'(ARENA_WORDS)};
      end else begin
         seg_ff <= seg_in;
      end
   end

   assign seg = seg_ff;

endmodule

// File: src/sorted_free_list_allocator_top.sv
// Top level of the sorted free-list allocator: control sequencer, block-length memory
// and the row of free-table cells. Depends on sfla_pkg and sfla_cell.
//
// An accepted request passes through these steps in order: one memory read of the
// block length, one full rotation of the cell row past its head, a decision, the
// change applied to the row, and the load of the result register, which waits while
// an earlier result is still held by rsp_stall. The next request can be taken in the
// cycle in which the result appears. One request is in flight at a time; the result
// register lets the next request be taken while a result still waits. Writing
// arena_size resets the free table to one segment and retires all allocated blocks
// at once. On every 256th such write the epoch mark wraps, and a background pass
// clears the block-length memory while requests stall.
module sorted_free_list_allocator_top #(
   parameter int MAX_FREE_SEGMENTS = sfla_pkg::DEFAULT_MAX_SEGMENTS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  sfla_pkg::req_item_type          req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output sfla_pkg::rsp_item_type          rsp_data,
   input  logic                            csr_write_enable,
   input  logic                            csr_index,
   input  logic [sfla_pkg::LEN_W-1:0]      csr_write_data
);
   import sfla_pkg::*;

   localparam int IDX_W = $clog2(MAX_FREE_SEGMENTS);
   localparam int CNT_W = $clog2(MAX_FREE_SEGMENTS + 1);
   localparam logic [CNT_W-1:0] LAST_K = CNT_W'(MAX_FREE_SEGMENTS - 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(MAX_FREE_SEGMENTS);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(ARENA_WORDS - 1);

   state_type state_ff, state_in;
   logic [1:0] fit_mode_ff, fit_mode_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [EPOCH_W-1:0] epoch_ff, epoch_in;
   logic clr_active_ff, clr_active_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic [CNT_W-1:0] k_ff, k_in;
   logic op_free_ff, op_free_in;
   logic [LEN_W-1:0] need_ff, need_in;
   logic [ADDR_W-1:0] h_ff, h_in;
   logic addr_zero_ff, addr_zero_in;
   logic found_ff, found_in;
   logic [CNT_W-1:0] pick_ff, pick_in;
   seg_type pick_seg_ff, pick_seg_in;
   logic [CNT_W-1:0] pos_ff, pos_in;
   seg_type prev_seg_ff, prev_seg_in;
   logic next_found_ff, next_found_in;
   seg_type next_seg_ff, next_seg_in;
   upd_kind_type kind_ff, kind_in;
   logic [IDX_W-1:0] upd_idx_ff, upd_idx_in;
   seg_type upd_seg_ff, upd_seg_in;
   logic [CNT_W-1:0] new_count_ff, new_count_in;
   logic mem_we_ff, mem_we_in;
   logic [ADDR_W-1:0] mem_addr_ff, mem_addr_in;
   blk_entry_type mem_wdata_ff, mem_wdata_in;
   rsp_item_type res_ff, res_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_data_ff, rsp_data_in;

   blk_entry_type blk_mem [ARENA_WORDS];
   blk_entry_type rd_ff;

   cell_ctl_type ctl;
   logic [IDX_W-1:0] ctl_idx;
   seg_type cells [MAX_FREE_SEGMENTS];

   genvar gi;
   generate
      for (gi = 0; gi < MAX_FREE_SEGMENTS; gi++) begin : g_cell
         sfla_cell #(
            .MAX_FREE_SEGMENTS(MAX_FREE_SEGMENTS),
            .INDEX(gi),
            .IDX_W(IDX_W)
         ) u_cell (
            .clock(clock),
            .reset(reset),
            .ctl(ctl),
            .idx(ctl_idx),
            .left_seg(cells[(gi == 0) ? 0 : gi - 1]),
            .right_seg(cells[(gi + 1) % MAX_FREE_SEGMENTS]),
            .seg(cells[gi])
         );
      end
   endgenerate

   logic [LEN_W-1:0] arena_sat;
   logic [ADDR_W-1:0] req_size_eff;
   seg_type head;
   logic [LEN_W:0] prev_end;
   logic [LEN_W:0] blk_end;
   logic blk_live;
   logic mprev, mnext;

   always_comb begin
      if (csr_write_data < LEN_W'(2)) begin
         arena_sat = LEN_W'(2);
      end else if (csr_write_data > LEN_W'(ARENA_WORDS)) begin
         arena_sat = LEN_W'(ARENA_WORDS);
      end else begin
         arena_sat = csr_write_data;
      end
      req_size_eff = (req_data.alloc_words == '0) ? ADDR_W'(1) : req_data.alloc_words;
      head = cells[0];
      prev_end = {2'b00, prev_seg_ff.start} + {1'b0, prev_seg_ff.length};
      blk_end = {2'b00, h_ff} + {1'b0, rd_ff.length};
      blk_live = !addr_zero_ff && (rd_ff.epoch == epoch_ff) && (rd_ff.length != '0);
      mprev = (pos_ff != '0) && (prev_end == {2'b00, h_ff});
      mnext = next_found_ff && ({2'b00, next_seg_ff.start} == blk_end);
   end

   always_comb begin
      state_in = state_ff;
      fit_mode_in = fit_mode_ff;
      count_in = count_ff;
      epoch_in = epoch_ff;
      clr_active_in = clr_active_ff;
      clr_addr_in = clr_addr_ff;
      k_in = k_ff;
      op_free_in = op_free_ff;
      need_in = need_ff;
      h_in = h_ff;
      addr_zero_in = addr_zero_ff;
      found_in = found_ff;
      pick_in = pick_ff;
      pick_seg_in = pick_seg_ff;
      pos_in = pos_ff;
      prev_seg_in = prev_seg_ff;
      next_found_in = next_found_ff;
      next_seg_in = next_seg_ff;
      kind_in = kind_ff;
      upd_idx_in = upd_idx_ff;
      upd_seg_in = upd_seg_ff;
      new_count_in = new_count_ff;
      mem_we_in = mem_we_ff;
      mem_addr_in = mem_addr_ff;
      mem_wdata_in = mem_wdata_ff;
      res_in = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      ctl = '{cmd: CMD_HOLD, kind: UPD_NONE, seg: '0};
      ctl_idx = upd_idx_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (clr_active_ff) begin
         clr_addr_in = clr_addr_ff + ADDR_W'(1);
         if (clr_addr_ff == LAST_ADDR) begin
            clr_active_in = 1'b0;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (csr_write_enable) begin
               unique case (csr_index)
                  CSR_FIT_MODE: fit_mode_in = csr_write_data[1:0];
                  CSR_ARENA_SIZE: begin
                     count_in = CNT_W'(1);
                     epoch_in = epoch_ff + EPOCH_W'(1);
                     if (epoch_ff == '1) begin
                        clr_active_in = 1'b1;
                        clr_addr_in = '0;
                     end
                     ctl = '{cmd: CMD_INIT, kind: UPD_NONE,
                             seg: '{start: '0, length: arena_sat}};
                  end
                  default: fit_mode_in = fit_mode_ff;
               endcase
            end else if (req_valid && !clr_active_ff) begin
               op_free_in = (req_data.req_type == REQ_FREE);
               need_in = {1'b0, req_size_eff} + LEN_W'(1);
               h_in = req_data.block_address - ADDR_W'(1);
               addr_zero_in = (req_data.block_address == '0);
               k_in = '0;
               found_in = 1'b0;
               pos_in = '0;
               next_found_in = 1'b0;
               state_in = ST_READ;
            end
         end
         ST_READ: state_in = ST_SCAN;
         ST_SCAN: begin
            ctl.cmd = CMD_ROTATE;
            if (k_ff < count_ff) begin
               if (!op_free_ff) begin
                  if (head.length >= need_ff) begin
                     if (fit_mode_ff == FIT_BEST) begin
                        if (!found_ff || head.length < pick_seg_ff.length) begin
                           found_in = 1'b1;
                           pick_in = k_ff;
                           pick_seg_in = head;
                        end
                     end else if (fit_mode_ff == FIT_WORST) begin
                        if (!found_ff || head.length > pick_seg_ff.length) begin
                           found_in = 1'b1;
                           pick_in = k_ff;
                           pick_seg_in = head;
                        end
                     end else if (!found_ff) begin
                        found_in = 1'b1;
                        pick_in = k_ff;
                        pick_seg_in = head;
                     end
                  end
               end else if (head.start <= h_ff) begin
                  pos_in = k_ff + CNT_W'(1);
                  prev_seg_in = head;
               end else if (!next_found_ff) begin
                  next_found_in = 1'b1;
                  next_seg_in = head;
               end
            end
            k_in = k_ff + CNT_W'(1);
            if (k_ff == LAST_K) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            kind_in = UPD_NONE;
            mem_we_in = 1'b0;
            new_count_in = count_ff;
            res_in = '{status: STATUS_OK, payload_address: '0, granted_size: '0};
            if (!op_free_ff) begin
               if (!found_ff) begin
                  res_in.status = STATUS_NO_FIT;
               end else begin
                  upd_idx_in = pick_ff[IDX_W-1:0];
                  mem_we_in = 1'b1;
                  mem_addr_in = pick_seg_ff.start;
                  mem_wdata_in.epoch = epoch_ff;
                  res_in.payload_address = pick_seg_ff.start + ADDR_W'(1);
                  if ({1'b0, pick_seg_ff.length} < {1'b0, need_ff} + (LEN_W+1)'(2)) begin
                     kind_in = UPD_DELETE;
                     new_count_in = count_ff - CNT_W'(1);
                     mem_wdata_in.length = pick_seg_ff.length;
                     res_in.granted_size = ADDR_W'(pick_seg_ff.length - LEN_W'(1));
                  end else begin
                     kind_in = UPD_MODIFY;
                     upd_seg_in.start = pick_seg_ff.start + need_ff[ADDR_W-1:0];
                     upd_seg_in.length = pick_seg_ff.length - need_ff;
                     mem_wdata_in.length = need_ff;
                     res_in.granted_size = ADDR_W'(need_ff - LEN_W'(1));
                  end
               end
            end else if (blk_live) begin
               mem_addr_in = h_ff;
               mem_wdata_in = '{epoch: epoch_ff, length: '0};
               res_in.payload_address = h_ff + ADDR_W'(1);
               res_in.granted_size = ADDR_W'(rd_ff.length - LEN_W'(1));
               mem_we_in = 1'b1;
               if (mprev && mnext) begin
                  kind_in = UPD_MODDEL;
                  upd_idx_in = pos_ff[IDX_W-1:0];
                  upd_seg_in.start = prev_seg_ff.start;
                  upd_seg_in.length = prev_seg_ff.length + rd_ff.length
                                      + next_seg_ff.length;
                  new_count_in = count_ff - CNT_W'(1);
               end else if (mprev) begin
                  kind_in = UPD_MODIFY;
                  upd_idx_in = IDX_W'(pos_ff - CNT_W'(1));
                  upd_seg_in.start = prev_seg_ff.start;
                  upd_seg_in.length = prev_seg_ff.length + rd_ff.length;
               end else if (mnext) begin
                  kind_in = UPD_MODIFY;
                  upd_idx_in = pos_ff[IDX_W-1:0];
                  upd_seg_in.start = h_ff;
                  upd_seg_in.length = next_seg_ff.length + rd_ff.length;
               end else if (count_ff >= FULL_COUNT) begin
                  mem_we_in = 1'b0;
                  res_in = '{status: STATUS_TABLE_FULL, payload_address: '0,
                             granted_size: '0};
               end else begin
                  kind_in = UPD_INSERT;
                  upd_idx_in = pos_ff[IDX_W-1:0];
                  upd_seg_in.start = h_ff;
                  upd_seg_in.length = rd_ff.length;
                  new_count_in = count_ff + CNT_W'(1);
               end
            end
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            ctl = '{cmd: CMD_UPDATE, kind: kind_ff, seg: upd_seg_ff};
            count_in = new_count_ff;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = res_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fit_mode_ff <= FIT_FIRST;
         count_ff <= CNT_W'(1);
         epoch_ff <= '0;
         clr_active_ff <= 1'b0;
         clr_addr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fit_mode_ff <= fit_mode_in;
         count_ff <= count_in;
         epoch_ff <= epoch_in;
         clr_active_ff <= clr_active_in;
         clr_addr_ff <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff <= k_in;
      op_free_ff <= op_free_in;
      need_ff <= need_in;
      h_ff <= h_in;
      addr_zero_ff <= addr_zero_in;
      found_ff <= found_in;
      pick_ff <= pick_in;
      pick_seg_ff <= pick_seg_in;
      pos_ff <= pos_in;
      prev_seg_ff <= prev_seg_in;
      next_found_ff <= next_found_in;
      next_seg_ff <= next_seg_in;
      kind_ff <= kind_in;
      upd_idx_ff <= upd_idx_in;
      upd_seg_ff <= upd_seg_in;
      new_count_ff <= new_count_in;
      mem_we_ff <= mem_we_in;
      mem_addr_ff <= mem_addr_in;
      mem_wdata_ff <= mem_wdata_in;
      res_ff <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (clr_active_ff) begin
         blk_mem[clr_addr_ff] <= '{epoch: '0, length: '0};
      end else if (state_ff == ST_UPDATE && mem_we_ff) begin
         blk_mem[mem_addr_ff] <= mem_wdata_ff;
      end
      rd_ff <= blk_mem[h_ff];
   end

   assign req_stall = (state_ff != ST_IDLE) || clr_active_ff || csr_write_enable;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

endmodule

// File: dv/sorted_free_list_allocator_top_tb.sv
// Self-checking testbench for the sorted free-list allocator top level.
// It holds its own model of the free table, drives requests and checks results.
// Depends on sfla_pkg and the RTL under src.
module sorted_free_list_allocator_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import sfla_pkg::*;

   localparam int NSEG = DEFAULT_MAX_SEGMENTS;
   localparam int LIMIT = 3000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_item_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_item_type rsp_data;
   logic csr_write_enable = 1'b0;
   logic csr_index = 1'b0;
   logic [LEN_W-1:0] csr_write_data = '0;

   sorted_free_list_allocator_top i_dut (.*);

   always #2 clock = ~clock;

   // Model state.
   int unsigned fl_start[NSEG];
   int unsigned fl_len[NSEG];
   int unsigned fl_count;
   int unsigned blk_len[ARENA_WORDS];
   int unsigned mdl_mode;
   int unsigned mdl_arena;

   rsp_item_type expected_rsp[$];
   int unsigned live_addr[$];
   int unsigned mismatches = 0;
   int unsigned rsp_seen = 0;
   int unsigned cycles = 0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   bit hold_rsp = 1'b0;
   int unsigned n_alloc = 0, n_free = 0, n_full = 0, n_nofit = 0;

   function automatic rsp_item_type mk(int unsigned st, int unsigned a, int unsigned s);
      rsp_item_type r;
      r.status = st[1:0];
      r.payload_address = a[ADDR_W-1:0];
      r.granted_size = s[ADDR_W-1:0];
      return r;
   endfunction

   function automatic void table_init();
      fl_count = 1;
      fl_start[0] = 0;
      fl_len[0] = mdl_arena;
      foreach (blk_len[k]) blk_len[k] = 0;
   endfunction

   function automatic void table_remove(int unsigned i);
      for (int unsigned k = i; k + 1 < fl_count; k++) begin
         fl_start[k] = fl_start[k+1];
         fl_len[k] = fl_len[k+1];
      end
      fl_count--;
   endfunction

   function automatic rsp_item_type predict_alloc(int unsigned req);
      int unsigned need, pick, s, total;
      bit found;
      pick = 0;
      found = 0;
      if (req == 0) req = 1;
      need = req + 1;
      for (int unsigned i = 0; i < fl_count; i++) begin
         if (fl_len[i] < need) continue;
         if (mdl_mode == FIT_BEST) begin
            if (!found || fl_len[i] < fl_len[pick]) begin pick = i; found = 1; end
         end else if (mdl_mode == FIT_WORST) begin
            if (!found || fl_len[i] > fl_len[pick]) begin pick = i; found = 1; end
         end else begin
            pick = i;
            found = 1;
            break;
         end
      end
      if (!found) return mk(STATUS_NO_FIT, 0, 0);
      s = fl_start[pick];
      if (fl_len[pick] - need < 2) begin
         total = fl_len[pick];
         table_remove(pick);
      end else begin
         total = need;
         fl_start[pick] = s + need;
         fl_len[pick] -= need;
      end
      blk_len[s] = total;
      return mk(STATUS_OK, s + 1, total - 1);
   endfunction

   function automatic rsp_item_type predict_free(int unsigned b);
      int unsigned h, len, e, pos;
      bit mp, mn;
      if (b == 0 || blk_len[b-1] == 0) return mk(STATUS_OK, 0, 0);
      h = b - 1;
      len = blk_len[h];
      e = h + len;
      pos = 0;
      while (pos < fl_count && fl_start[pos] <= h) pos++;
      mp = pos > 0 && fl_start[pos-1] + fl_len[pos-1] == h;
      mn = pos < fl_count && fl_start[pos] == e;
      if (mp && mn) begin
         fl_len[pos-1] += len + fl_len[pos];
         table_remove(pos);
      end else if (mp) begin
         fl_len[pos-1] += len;
      end else if (mn) begin
         fl_start[pos] = h;
         fl_len[pos] += len;
      end else begin
         if (fl_count >= NSEG) return mk(STATUS_TABLE_FULL, 0, 0);
         for (int unsigned k = fl_count; k > pos; k--) begin
            fl_start[k] = fl_start[k-1];
            fl_len[k] = fl_len[k-1];
         end
         fl_start[pos] = h;
         fl_len[pos] = len;
         fl_count++;
      end
      blk_len[h] = 0;
      return mk(STATUS_OK, b, len - 1);
   endfunction

   // Predicts the result, tracks live addresses, and queues the expectation.
   function automatic void predict_item(req_item_type it);
      rsp_item_type r;
      if (it.req_type == REQ_ALLOC) begin
         r = predict_alloc(32'(it.alloc_words));
         if (r.status == STATUS_OK) live_addr.push_back(32'(r.payload_address));
         else n_nofit++;
         n_alloc++;
      end else begin
         r = predict_free(32'(it.block_address));
         if (r.status == STATUS_TABLE_FULL) n_full++;
         else if (r.granted_size != 0 || r.payload_address != 0) begin
            foreach (live_addr[k])
               if (live_addr[k] == it.block_address) begin
                  live_addr.delete(k);
                  break;
               end
         end
         n_free++;
      end
      expected_rsp.push_back(r);
   endfunction

   // Only frees of never-written addresses must be avoided: an address is safe
   // when it is zero or was granted since the last arena write.
   int unsigned ever_granted[$];

   function automatic bit safe_free(int unsigned a);
      if (a == 0) return 1;
      foreach (ever_granted[k]) if (ever_granted[k] == a) return 1;
      return 0;
   endfunction

   task automatic send_item(req_item_type it, bit check_fixed = 0,
                            rsp_item_type fixed = '0);
      rsp_item_type r;
      bit idle;
      idle = send_idle_pct != 0 && $urandom_range(99) < send_idle_pct;
      if (idle) begin
         req_valid <= 1'b0;
         while (idle) begin
            @(posedge clock);
            idle = $urandom_range(99) < send_idle_pct;
         end
      end
      predict_item(it);
      if (check_fixed) begin
         r = expected_rsp[$];
         if (r !== fixed) begin
            mismatches++;
            if (mismatches <= 10)
               $display("directed row predicted %h, table says %h", r, fixed);
         end
      end
      if (it.req_type == REQ_ALLOC && expected_rsp[$].status == STATUS_OK)
         ever_granted.push_back(32'(expected_rsp[$].payload_address));
      req_valid <= 1'b1;
      req_data <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (NSEG + 20) @(posedge clock);
   endtask

   task automatic csr_write(logic idx, int unsigned v);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= v[LEN_W-1:0];
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_FIT_MODE) begin
         mdl_mode = v & 3;
      end else begin
         mdl_arena = v & 11'h7FF;
         if (mdl_arena < 2) mdl_arena = 2;
         if (mdl_arena > ARENA_WORDS) mdl_arena = ARENA_WORDS;
         table_init();
         live_addr.delete();
         ever_granted.delete();
      end
      @(posedge clock);
   endtask

   function automatic req_item_type alloc_item(int unsigned sz);
      req_item_type it;
      it.req_type = REQ_ALLOC;
      it.alloc_words = sz[ADDR_W-1:0];
      it.block_address = ADDR_W'($urandom());
      return it;
   endfunction

   function automatic req_item_type free_item(int unsigned a);
      req_item_type it;
      it.req_type = REQ_FREE;
      it.block_address = a[ADDR_W-1:0];
      it.alloc_words = ADDR_W'($urandom());
      return it;
   endfunction

   // Result checker.
   always @(posedge clock) begin
      rsp_item_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_seen++;
         if (expected_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result item %h", rsp_data);
         end else begin
            e = expected_rsp.pop_front();
            if (rsp_data.status !== e.status || rsp_data.payload_address !== e.payload_address
                || rsp_data.granted_size !== e.granted_size) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                           e.status, e.payload_address, e.granted_size, rsp_data.status,
                           rsp_data.payload_address, rsp_data.granted_size);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (hold_rsp) rsp_stall <= 1'b1;
      else rsp_stall <= recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("sorted_free_list_allocator_top_tb: FAIL");
         $finish;
      end
   end

   // Directed rows: request, whether the result is fixed, and that result.
   typedef struct {
      req_item_type it;
      bit fixed;
      rsp_item_type r;
   } dir_row_type;

   task automatic random_phase(int unsigned n);
      int unsigned k, a;
      for (int unsigned i = 0; i < n; i++) begin
         k = $urandom_range(99);
         if (k < 50) begin
            if ($urandom_range(9) == 0) a = $urandom_range(1023);
            else if ($urandom_range(3) == 0) a = $urandom_range(60);
            else a = $urandom_range(12);
            send_item(alloc_item(a));
         end else if (k < 90 && live_addr.size() != 0) begin
            send_item(free_item(live_addr[$urandom_range(live_addr.size() - 1)]));
         end else begin
            if (ever_granted.size() != 0 && $urandom_range(1) == 0)
               a = ever_granted[$urandom_range(ever_granted.size() - 1)];
            else a = 0;
            send_item(free_item(a));
         end
      end
   endtask

   initial begin
      dir_row_type rows[$];
      int unsigned hold_count;
      mdl_mode = FIT_FIRST;
      mdl_arena = ARENA_WORDS;
      table_init();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      rows.push_back('{alloc_item(1023), 1, mk(STATUS_OK, 1, 1023)});
      rows.push_back('{free_item(1), 1, mk(STATUS_OK, 1, 1023)});
      rows.push_back('{alloc_item(0), 1, mk(STATUS_OK, 1, 1)});
      rows.push_back('{alloc_item(1), 1, mk(STATUS_OK, 3, 1)});
      rows.push_back('{alloc_item(5), 0, '0});
      rows.push_back('{alloc_item(3), 0, '0});
      rows.push_back('{free_item(0), 1, mk(STATUS_OK, 0, 0)});
      rows.push_back('{free_item(3), 1, mk(STATUS_OK, 3, 1)});
      rows.push_back('{free_item(3), 1, mk(STATUS_OK, 0, 0)});
      rows.push_back('{free_item(1), 0, '0});
      rows.push_back('{alloc_item(1011), 0, '0});
      rows.push_back('{alloc_item(512), 0, '0});
      foreach (rows[i]) send_item(rows[i].it, rows[i].fixed, rows[i].r);
      drain();

      // Small arena: whole-segment grant, saturation, and the other fit modes.
      csr_write(CSR_ARENA_SIZE, 0);
      send_item(alloc_item(1), 1, mk(STATUS_OK, 1, 1));
      send_item(alloc_item(1), 1, mk(STATUS_NO_FIT, 0, 0));
      send_item(free_item(1));
      drain();
      csr_write(CSR_ARENA_SIZE, 11'h7FF);
      csr_write(CSR_FIT_MODE, FIT_BEST);
      send_item(alloc_item(1022), 1, mk(STATUS_OK, 1, 1023));
      send_item(free_item(1));
      send_item(alloc_item(10));
      send_item(alloc_item(2));
      drain();
      csr_write(CSR_FIT_MODE, 3);
      send_item(alloc_item(4));
      drain();
      csr_write(CSR_FIT_MODE, FIT_WORST);
      send_item(alloc_item(7));
      drain();

      // Fill the table: many single blocks, free every other one.
      csr_write(CSR_ARENA_SIZE, ARENA_WORDS);
      csr_write(CSR_FIT_MODE, FIT_FIRST);
      for (int i = 0; i < 140; i++) send_item(alloc_item(1));
      for (int i = 0; i < 140; i += 2) send_item(free_item(2 * i + 1));
      drain();

      // Long receiver hold while requests keep coming.
      csr_write(CSR_ARENA_SIZE, 300);
      hold_rsp = 1'b1;
      fork
         begin
            hold_count = 0;
            while (hold_count < 2000) begin
               @(posedge clock);
               hold_count++;
            end
            hold_rsp = 1'b0;
         end
         for (int i = 0; i < 6; i++) send_item(alloc_item($urandom_range(20)));
      join
      drain();

      send_idle_pct = 11;
      recv_idle_pct = 83;
      csr_write(CSR_ARENA_SIZE, 200);
      csr_write(CSR_FIT_MODE, FIT_BEST);
      random_phase(140);
      drain();
      send_idle_pct = 83;
      recv_idle_pct = 11;
      csr_write(CSR_ARENA_SIZE, 2 + $urandom_range(1022));
      csr_write(CSR_FIT_MODE, FIT_WORST);
      random_phase(130);
      drain();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      csr_write(CSR_ARENA_SIZE, ARENA_WORDS);
      csr_write(CSR_FIT_MODE, $urandom_range(3));
      random_phase(140);
      drain();

      $display("Ran %0d allocates (%0d without fit) and %0d frees (%0d with a full table).",
               n_alloc, n_nofit, n_free, n_full);
      $display("Checked %0d result items across all fit modes and several arena sizes.",
               rsp_seen);
      if (mismatches == 0 && expected_rsp.size() == 0) begin
         $display("sorted_free_list_allocator_top_tb: PASS");
      end else begin
         $display("mismatches: %0d, results left over: %0d", mismatches, expected_rsp.size());
         $display("sorted_free_list_allocator_top_tb: FAIL");
      end
      $finish;
   end
endmodule

// File: filelist.f
src/sfla_pkg.sv
src/sfla_cell.sv
src/sorted_free_list_allocator_top.sv
dv/sorted_free_list_allocator_top_tb.sv
